// File: sv/fir_pkg.sv
// Shared types and constants for the FIR filter.
// No dependencies; imported by every module of the filter.
package fir_pkg;

    localparam int MAX_TAPS    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int COEFF_BITS  = 16;
    localparam int PROD_BITS   = SAMPLE_BITS + COEFF_BITS;
    localparam int SUM_BITS    = 40;
    localparam int TAPS_BITS   = 5;
    localparam int INDEX_BITS  = 4;

    localparam logic [TAPS_BITS-1:0] NUM_TAPS_RESET = 5'd16;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_LOAD   = 2'd1,
        FUNC_FILTER = 2'd2
    } func_t;

    // Per-cycle control broadcast to every cell of the chain
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

// File: sv/fir_cell.sv
// One tap of the FIR chain: delay stage, coefficient, product and partial sum.
// Depends on fir_pkg.
module fir_cell
    import fir_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cell_ctrl_t                  ctrl,
    input  logic                        load_en,
    input  logic                        tap_on,
    input  logic signed [COEFF_BITS-1:0]  coeff_in,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic signed [SUM_BITS-1:0]    psum_in,
    input  logic                        tok_in,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic signed [SUM_BITS-1:0]    psum_out,
    output logic                        tok_out
);

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] sample_next;
    logic signed [COEFF_BITS-1:0]  coeff_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [SUM_BITS-1:0]    psum_reg;
    logic signed [SUM_BITS-1:0]    psum_next;
    logic                          tok_reg;

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            sample_next = '0;
        end
        else if (ctrl.shift)
        begin
            sample_next = sample_in;
        end
        else
        begin
            sample_next = sample_reg;
        end
    end

    // Inactive taps contribute nothing
    assign prod_next = tap_on ? PROD_BITS'(coeff_reg * sample_reg) : '0;
    assign psum_next = psum_in + SUM_BITS'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            tok_reg    <= 1'b0;
        end
        else
        begin
            sample_reg <= sample_next;
            tok_reg    <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            coeff_reg <= coeff_in;
        end
        prod_reg <= prod_next;
        if (tok_in)
        begin
            psum_reg <= psum_next;
        end
    end

    assign sample_out = sample_reg;
    assign psum_out   = psum_reg;
    assign tok_out    = tok_reg;

endmodule

// File: sv/fir_filter.sv
// FIR filter top level: command decode, cell chain and output register.
// Depends on fir_pkg and fir_cell.
//
// Streaming direct-form FIR filter built as a row of MAX_TAPS cells. Each cell holds one
// delay-line sample and one coefficient and multiplies them every cycle. A sample transfer
// shifts the delay line; a start token passes start1_reg and start2_reg, then a partial sum
// enters the first cell and walks the chain one cell per cycle, each active tap adding its
// product. in_stall stays high until the result moves into the output register, so no new
// sample is taken while one is in flight. Load and clear transfers give no result. Coefficients
// are undefined until loaded; num_taps (0 to 16, 0 turns all taps off, above 16 acts as 16) is
// to be written by the user only while no sample is in flight; the block does not enforce it.
module fir_filter
    import fir_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [TAPS_BITS-1:0]          cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    func,
    input  logic [INDEX_BITS-1:0]         coeff_index,
    input  logic signed [COEFF_BITS-1:0]  coeff_value,
    input  logic signed [SAMPLE_BITS-1:0] sample_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SUM_BITS-1:0]    filtered_value
);

    logic [TAPS_BITS-1:0]        num_taps_reg;
    logic                        busy_reg;
    logic                        busy_next;
    logic                        start1_reg;
    logic                        start2_reg;
    logic                        fin_reg;
    logic                        fin_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [SUM_BITS-1:0]  out_data_reg;

    logic                        in_xfer;
    logic                        do_load;
    logic                        do_filter;
    logic                        pending;
    logic                        move;
    cell_ctrl_t                  ctrl;

    logic signed [SAMPLE_BITS-1:0] sample_chain [MAX_TAPS+1];
    logic signed [SUM_BITS-1:0]    psum_chain   [MAX_TAPS+1];
    logic                          tok_chain    [MAX_TAPS+1];

    assign in_xfer = in_valid & ~in_stall;

    always_comb
    begin
        ctrl.shift = 1'b0;
        ctrl.clear = 1'b0;
        do_load    = 1'b0;
        do_filter  = 1'b0;
        if (in_xfer)
        begin
            unique case (func_t'(func))
                FUNC_CLEAR:  ctrl.clear = 1'b1;
                FUNC_LOAD:   do_load    = 1'b1;
                FUNC_FILTER:
                begin
                    ctrl.shift = 1'b1;
                    do_filter  = 1'b1;
                end
                default:     ;
            endcase
        end
    end

    assign sample_chain[0] = sample_value;
    assign psum_chain[0]   = '0;
    assign tok_chain[0]    = start2_reg;

    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        logic load_en;
        logic tap_on;

        assign load_en = do_load & (32'(coeff_index) == k);
        assign tap_on  = 32'(num_taps_reg) > k;

        fir_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .load_en    (load_en),
            .tap_on     (tap_on),
            .coeff_in   (coeff_value),
            .sample_in  (sample_chain[k]),
            .psum_in    (psum_chain[k]),
            .tok_in     (tok_chain[k]),
            .sample_out (sample_chain[k+1]),
            .psum_out   (psum_chain[k+1]),
            .tok_out    (tok_chain[k+1])
        );
    end

    // Finished sum waits in the last cell until the output register is free
    assign pending = fin_reg | tok_chain[MAX_TAPS];
    assign move    = pending & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        fin_next  = pending & ~move;
        busy_next = busy_reg;
        if (do_filter)
        begin
            busy_next = 1'b1;
        end
        else if (move)
        begin
            busy_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg & ~out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_taps_reg  <= NUM_TAPS_RESET;
            busy_reg      <= 1'b0;
            start1_reg    <= 1'b0;
            start2_reg    <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                num_taps_reg <= cfg_wr_data;
            end
            busy_reg      <= busy_next;
            start1_reg    <= do_filter;
            start2_reg    <= start1_reg;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_data_reg <= psum_chain[MAX_TAPS];
        end
    end

    assign in_stall       = busy_reg;
    assign out_valid      = out_valid_reg;
    assign filtered_value = out_data_reg;

endmodule

// File: sv/fir_filter_chk.sv
// Port-level checks for the FIR filter, bound to the top level.
// Depends on fir_pkg and fir_filter.
module fir_filter_chk
    import fir_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_wr_en,
    input logic [TAPS_BITS-1:0]          cfg_wr_data,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [1:0]                    func,
    input logic [INDEX_BITS-1:0]         coeff_index,
    input logic signed [COEFF_BITS-1:0]  coeff_value,
    input logic signed [SAMPLE_BITS-1:0] sample_value,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SUM_BITS-1:0]    filtered_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(filtered_value))
        else $error("stalled result changed");

    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func == FUNC_FILTER |=> in_stall)
        else $error("input not stalled after sample transfer");

    a_no_stall_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func != FUNC_FILTER |=> !in_stall)
        else $error("load or clear transfer left input stalled");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no sample in flight");

endmodule

bind fir_filter fir_filter_chk u_fir_filter_chk (.*);
